/* rtl/llh_pkg.sv */
// Shared types and constants for the line letter histogram unit.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package llh_pkg;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CODE_W      = 7;
  localparam int unsigned VAL_W       = 9;

  localparam logic [7:0] BYTE_NEWLINE = 8'd10;
  localparam logic [7:0] BYTE_SPACE   = 8'd32;
  localparam logic [7:0] UPPER_A      = 8'd65;
  localparam logic [7:0] LOWER_A      = 8'd97;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LETTERS - 1);

  // result kinds
  localparam logic KIND_WORDS  = 1'b0;
  localparam logic KIND_LETTER = 1'b1;

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_WORD,
    ST_LETTERS
  } state_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic inc_en;  // count the broadcast byte if it matches
    logic shift;   // take the neighbor's count
  } cell_ctrl_t;

endpackage

/* rtl/llh_cell.sv */
// One histogram cell: a saturating count for a single letter.
// Shifts its count toward the head of the chain during readout. Uses llh_pkg.
`timescale 1ns / 1ps

module llh_cell #(
  parameter int unsigned LETTER = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  llh_pkg::cell_ctrl_t       ctrl_i,
  input  logic [7:0]                char_byte_i,
  input  logic [llh_pkg::CNT_W-1:0] count_i,
  input  logic                      tail_nz_i,
  output logic [llh_pkg::CNT_W-1:0] count_o,
  output logic                      tail_nz_o
);
  import llh_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             hit;

  // case-folded letter match
  assign hit = (char_byte_i == 8'(UPPER_A + LETTER)) ||
               (char_byte_i == 8'(LOWER_A + LETTER));

  // shift has priority; increment saturates
  always_comb begin
    count_d = count_q;
    if (ctrl_i.shift) begin
      count_d = count_i;
    end else if (ctrl_i.inc_en && hit && (count_q != CNT_MAX)) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o   = count_q;
  // any nonzero count from this cell to the end of the chain
  assign tail_nz_o = (count_q != '0) || tail_nz_i;

endmodule

/* rtl/line_letter_histogram_unit.sv */
// Line letter histogram top level: byte input, cell chain, readout sequencer.
// Depends on llh_pkg and llh_cell.
`timescale 1ns / 1ps

// Takes one character byte per cycle while a line is collected. A newline
// starts the readout: the word count (spaces plus one) comes first, then the
// cell chain shifts one letter toward the head per cycle, holding while a
// nonzero head count waits on an output stall, and each nonzero letter count is
// sent, with last_of_line on the final word of the line. Readout ends early when
// the trailing letters are absent; input is stalled for the whole readout.
// Letter and space counts saturate at 255; only the first MAX_LINE_CHARS bytes
// of a line are counted.
module line_letter_histogram_unit #(
  parameter int unsigned MAX_LINE_CHARS = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 char_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       result_kind_o,
  output logic [llh_pkg::CODE_W-1:0] letter_code_o,
  output logic [llh_pkg::VAL_W-1:0]  count_value_o,
  output logic                       last_of_line_o
);
  import llh_pkg::*;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE_CHARS);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] space_q, space_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic              out_valid_q;
  logic              kind_q;
  logic [CODE_W-1:0] code_q;
  logic [VAL_W-1:0]  value_q;
  logic              last_q;

  cell_ctrl_t       cell_ctrl;
  logic [CNT_W-1:0] chain_cnt [NUM_LETTERS+1];
  logic             chain_nz  [NUM_LETTERS+1];

  logic in_acc, is_newline, out_free, load_word, load_letter, room;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_newline = (char_byte_i == BYTE_NEWLINE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign room       = (len_q < LEN_LIMIT);

  // cell chain: cell 0 is the head, zeros enter at the tail
  assign chain_cnt[NUM_LETTERS] = '0;
  assign chain_nz[NUM_LETTERS]  = 1'b0;

  for (genvar g = 0; g < NUM_LETTERS; g++) begin : g_cell
    llh_cell #(
      .LETTER (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .char_byte_i (char_byte_i),
      .count_i     (chain_cnt[g+1]),
      .tail_nz_i   (chain_nz[g+1]),
      .count_o     (chain_cnt[g]),
      .tail_nz_o   (chain_nz[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COUNT: begin
        if (in_acc && is_newline) state_d = ST_WORD;
      end
      ST_WORD: begin
        if (out_free) state_d = chain_nz[0] ? ST_LETTERS : ST_COUNT;
      end
      ST_LETTERS: begin
        // leave as soon as the final letter word is loaded
        if (!chain_nz[0] || (load_letter && !chain_nz[1])) state_d = ST_COUNT;
      end
      default: state_d = ST_COUNT;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o       = 1'b1;
    cell_ctrl.inc_en = 1'b0;
    cell_ctrl.shift  = 1'b0;
    load_word        = 1'b0;
    load_letter      = 1'b0;
    case (state_q)
      ST_COUNT: begin
        in_stall_o       = 1'b0;
        cell_ctrl.inc_en = in_acc && !is_newline && room;
      end
      ST_WORD: begin
        load_word = out_free;
      end
      ST_LETTERS: begin
        if (chain_nz[0]) begin
          if (chain_cnt[0] == '0) begin
            cell_ctrl.shift = 1'b1;
          end else if (out_free) begin
            load_letter     = 1'b1;
            cell_ctrl.shift = 1'b1;
          end
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // line counters and readout index
  always_comb begin
    space_d = space_q;
    len_d   = len_q;
    idx_d   = idx_q;
    if (in_acc && !is_newline) begin
      if (room && (char_byte_i == BYTE_SPACE) && (space_q != CNT_MAX)) begin
        space_d = space_q + CNT_W'(1);
      end
      if (len_q != {LEN_W{1'b1}}) len_d = len_q + LEN_W'(1);
    end
    if (load_word) begin
      space_d = '0;
      len_d   = '0;
      idx_d   = '0;
    end
    if (cell_ctrl.shift) idx_d = idx_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
      idx_q   <= '0;
      space_q <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      space_q <= space_d;
      len_q   <= len_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_word || load_letter) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_word) begin
      kind_q  <= KIND_WORDS;
      code_q  <= '0;
      value_q <= VAL_W'(space_q) + VAL_W'(1);
      last_q  <= !chain_nz[0];
    end else if (load_letter) begin
      kind_q  <= KIND_LETTER;
      code_q  <= CODE_W'(LOWER_A) + CODE_W'(idx_q);
      value_q <= VAL_W'(chain_cnt[0]);
      last_q  <= !chain_nz[1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign letter_code_o  = code_q;
  assign count_value_o  = value_q;
  assign last_of_line_o = last_q;

`ifndef ASSERT_OFF
  // readout index stays within the alphabet while letters remain
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LETTERS && chain_nz[0]) |-> (idx_q <= IDX_LAST))
    else $error("readout index beyond last letter");

  // a final word ends the readout
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((load_word || load_letter) && !chain_nz[1] && !(load_word && chain_nz[0]))
      |=> (state_q == ST_COUNT))
    else $error("readout continued after final word");

  // letter words never carry a zero count
  a_letter_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_letter |=> (count_value_o != '0))
    else $error("letter word with zero count");

  // no byte is taken while a readout is in progress
  a_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl.shift || load_word) |-> !cell_ctrl.inc_en)
    else $error("count and shift in the same cycle");
`endif

endmodule

/* dv/tb.sv */
// Testbench for line_letter_histogram_unit: feeds text lines one byte at a time,
// predicts the word count and letter histogram of each line and checks each result.
// Depends on llh_pkg and the RTL top level under rtl/.
`timescale 1ns / 1ps

module tb;
  import llh_pkg::*;

  localparam int unsigned MAX_LINE = 255;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  count;
    logic              last;
  } hist_word_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [7:0]        char_byte_i = 8'd0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              result_kind_o;
  logic [CODE_W-1:0] letter_code_o;
  logic [VAL_W-1:0]  count_value_o;
  logic              last_of_line_o;

  // predicted line state and the histogram words still owed by the block
  logic [CNT_W-1:0] letter_tally [NUM_LETTERS];
  logic [CNT_W-1:0] space_tally;
  logic [LEN_W-1:0] line_len;
  hist_word_t       histogram_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int n_errors  = 0;

  line_letter_histogram_unit #(
    .MAX_LINE_CHARS(MAX_LINE)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .letter_code_o (letter_code_o),
    .count_value_o (count_value_o),
    .last_of_line_o(last_of_line_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_tally();
    foreach (letter_tally[i]) letter_tally[i] = '0;
    space_tally = '0;
    line_len    = '0;
  endtask

  // Update the line state with one byte; a newline pushes the line's histogram.
  task automatic tally_char(input logic [7:0] b);
    int         last_idx;
    int         idx;
    hist_word_t w;
    if (b != BYTE_NEWLINE) begin
      if (line_len < LEN_W'(MAX_LINE)) begin
        idx = -1;
        if (b >= UPPER_A && b < UPPER_A + 8'(NUM_LETTERS)) idx = int'(b - UPPER_A);
        if (b >= LOWER_A && b < LOWER_A + 8'(NUM_LETTERS)) idx = int'(b - LOWER_A);
        if (b == BYTE_SPACE) begin
          if (space_tally != CNT_MAX) space_tally++;
        end else if (idx >= 0) begin
          if (letter_tally[idx] != CNT_MAX) letter_tally[idx]++;
        end
      end
      if (line_len != '1) line_len++;
    end else begin
      last_idx = -1;
      for (int i = 0; i < NUM_LETTERS; i++) if (letter_tally[i] != '0) last_idx = i;
      w.kind  = KIND_WORDS;
      w.code  = '0;
      w.count = VAL_W'(space_tally) + 1'b1;
      w.last  = (last_idx < 0);
      histogram_q.push_back(w);
      for (int i = 0; i < NUM_LETTERS; i++) begin
        if (letter_tally[i] != '0) begin
          w.kind  = KIND_LETTER;
          w.code  = CODE_W'(LOWER_A) + CODE_W'(i);
          w.count = VAL_W'(letter_tally[i]);
          w.last  = (i == last_idx);
          histogram_q.push_back(w);
        end
      end
      clear_tally();
    end
  endtask

  // Offer one byte, with optional idle cycles first, and wait until it is taken.
  task automatic send_char(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    tally_char(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // All 26 letters in shuffled order and random case, then a newline.
  task automatic send_alphabet_line();
    int order [NUM_LETTERS];
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i])
      send_char(($urandom_range(1) ? LOWER_A : UPPER_A) + 8'(order[i]));
    send_char(BYTE_NEWLINE);
  endtask

  // A line drawn from a random span of the alphabet, spaces and arbitrary bytes.
  task automatic send_random_line(input int len);
    int         lo;
    int         hi;
    int         r;
    logic [7:0] b;
    lo = $urandom_range(NUM_LETTERS - 1);
    hi = $urandom_range(NUM_LETTERS - 1, lo);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 40)      b = LOWER_A + 8'($urandom_range(hi, lo));
      else if (r < 60) b = UPPER_A + 8'($urandom_range(hi, lo));
      else if (r < 75) b = BYTE_SPACE;
      else             b = 8'($urandom_range(255));
      send_char(b);
    end
    send_char(BYTE_NEWLINE);
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // empty line
    send_char(BYTE_NEWLINE);
    // letter range edges and their neighbors, byte extremes
    send_text("AZaz @[`{");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(BYTE_NEWLINE);
    // a space and a digit but no letters
    send_text(" 9\n");
  endtask

  task automatic test_full_alphabet();
    send_alphabet_line();
    send_text("zZz\n");
    send_text("a\n");
  endtask

  task automatic test_saturation();
    // word count tops out at 256; letters past the line limit are dropped
    for (int i = 0; i < 255; i++) send_char(BYTE_SPACE);
    send_text("aaaaa\n");
  endtask

  // Long output hold-off while input keeps coming, so the unit backs up.
  task automatic test_backpressure();
    idle_pct  = 0;
    hold_left = 400;
    send_text("hold off\n");
    send_text("ab\n");
  endtask

  task automatic run_random(input int idle, input int stall, input int n_items);
    int sent;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_items) begin
      len = $urandom_range(10, 0);
      send_random_line(len);
      sent += len + 1;
    end
  endtask

  task automatic test_random_phases();
    run_random(0, 0, 10);
    run_random(66, 0, 10);
    run_random(0, 66, 10);
    run_random(10, 10, 10);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Output stall: a requested hold-off first, otherwise random per phase.
  initial begin : out_stall_drive
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  initial begin : result_check
    hist_word_t want;
    hist_word_t got;
    logic       take;
    forever begin
      @(posedge clk_i);
      take = rst_ni && out_valid_o && !out_stall_i;
      got  = '{result_kind_o, letter_code_o, count_value_o, last_of_line_o};
      // let the sender record a newline taken at this same edge
      #1;
      if (take) begin
        if (histogram_q.size() == 0) begin
          $error("unexpected result: kind %0d code %0d count %0d last %0d",
                 got.kind, got.code, got.count, got.last);
          n_errors++;
        end else begin
          want = histogram_q.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("letter_code", want.code, got.code);
          check_field("count_value", want.count, got.count);
          check_field("last_of_line", want.last, got.last);
        end
      end
    end
  end

  initial begin : main
    int guard;
    clear_tally();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_alphabet();
    test_saturation();
    test_backpressure();
    test_random_phases();

    // drain the remaining results
    in_valid_i <= 1'b0;
    guard = 0;
    while (histogram_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (histogram_q.size() != 0) begin
      $error("%0d predicted results never arrived", histogram_q.size());
      n_errors++;
    end

    if (n_errors == 0) begin
      $display("line_letter_histogram_unit: match");
    end else begin
      $display("line_letter_histogram_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("line_letter_histogram_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/llh_pkg.sv
rtl/llh_cell.sv
rtl/line_letter_histogram_unit.sv
dv/tb.sv
